// File: rtl/bitmap_block_allocator_macros.svh
// Assertion macros for the bitmap block allocator checker.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Condition implies consequence in the same cycle.
`define BBA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the following cycle.
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bba_pkg.sv
// Package for the bitmap block allocator: sizes, codes, item and control types.
`default_nettype none

package bba_pkg;

  // Disk geometry limits and map layout
  localparam int MAX_BLOCKS         = 4096;
  localparam int BITS_PER_MAP_BLOCK = 4096;
  localparam int INODE_TOTAL        = 1024;
  localparam int INODE_BLOCKS       = INODE_TOTAL / 4;
  localparam int MAP_WORD_BITS      = 32;

  // Field widths
  localparam int BLK_W  = 12;
  localparam int CNT_W  = 13;
  localparam int REG_W  = 7;
  localparam int CFG_AW = 2;

  // Operation codes
  localparam logic [1:0] OP_FORMAT = 2'd0;
  localparam logic [1:0] OP_ALLOC  = 2'd1;
  localparam logic [1:0] OP_FREE   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NO_SPACE     = 2'd1;
  localparam logic [1:0] ST_ALREADY_FREE = 2'd2;
  localparam logic [1:0] ST_RANGE        = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_CYLINDERS = 2'd0;
  localparam logic [CFG_AW-1:0] REG_SECTORS   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_INODES    = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [BLK_W-1:0] block_number;
  } in_item_t;

  typedef struct packed {
    logic [BLK_W-1:0] allocated_block;
    logic [1:0]       status;
    logic [CNT_W-1:0] free_count;
  } out_item_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       start;         // latch item, clear word counter and result
    logic       geom;          // latch total, first data block, free count
    logic       fmt_write;     // write one format word, advance
    logic       scan;          // issue next scan read, check returned word
    logic       free_read;     // read the word holding the block to free
    logic       alloc_commit;  // set the found bit, count down
    logic       free_commit;   // clear the block bit, count up
    logic       status_we;     // load result status
    logic [1:0] status_val;
    logic       finish;        // load output register
  } bba_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       count_zero;
    logic       bno_range;
    logic       fmt_last;
    logic       scan_hit;
    logic       scan_done;
    logic       bit_used;
  } bba_stat_t;

endpackage

`default_nettype wire

// File: rtl/bitmap_block_allocator.sv
// Steps from the accepting edge to a valid result: format runs decode, one write per map
// word, then finish; free runs decode, a map read, the check, then finish, and goes from
// decode to finish when the block is out of range; an unused op goes from decode to finish.
// Allocate scans the map word by word after decode, or goes from decode to finish when the
// free count is zero. One item at a time: input is ready again when the result loads, so a
// new item is not taken before the last is through; a stalled result holds the finish step.
// Synchronous reset clears control state and the map geometry; no map sweep.
`default_nettype none

module bitmap_block_allocator import bba_pkg::*; #(
  parameter int WORD_BITS = MAP_WORD_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [REG_W-1:0]  cfg_data
);

  localparam int WORDS = MAX_BLOCKS / WORD_BITS;
  localparam int AW    = $clog2(WORDS);

  bba_cmd_t             cmd;
  bba_stat_t            st;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  bba_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/bba_ctrl.sv
// Controller state machine for the bitmap block allocator.
`default_nettype none

module bba_ctrl import bba_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire bba_stat_t st,
  output bba_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FORMAT,
    S_SCAN,
    S_FREE_CHK,
    S_FINISH
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.op)
          OP_FORMAT: begin
            cmd.geom   = 1'b1;
            state_next = S_FORMAT;
          end
          OP_ALLOC: begin
            if (st.count_zero) begin
              cmd.status_we  = 1'b1;
              cmd.status_val = ST_NO_SPACE;
              state_next     = S_FINISH;
            end else begin
              state_next = S_SCAN;
            end
          end
          OP_FREE: begin
            if (st.bno_range) begin
              cmd.status_we  = 1'b1;
              cmd.status_val = ST_RANGE;
              state_next     = S_FINISH;
            end else begin
              cmd.free_read = 1'b1;
              state_next    = S_FREE_CHK;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_FORMAT: begin
        cmd.fmt_write = 1'b1;
        if (st.fmt_last) begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_hit) begin
          cmd.alloc_commit = 1'b1;
          state_next       = S_FINISH;
        end else if (st.scan_done) begin
          cmd.status_we  = 1'b1;
          cmd.status_val = ST_NO_SPACE;
          state_next     = S_FINISH;
        end
      end
      S_FREE_CHK: begin
        if (st.bit_used) begin
          cmd.free_commit = 1'b1;
        end else begin
          cmd.status_we  = 1'b1;
          cmd.status_val = ST_ALREADY_FREE;
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free or being drained
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/bba_dp.sv
// Datapath for the bitmap block allocator: registers, counters, map word logic.
`default_nettype none

module bba_dp import bba_pkg::*; #(
  parameter int WORD_BITS = MAP_WORD_BITS,
  localparam int WORDS = MAX_BLOCKS / WORD_BITS,
  localparam int AW = $clog2(WORDS),
  localparam int BW = $clog2(WORD_BITS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire in_item_t             in_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_AW-1:0]    cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data,
  input  wire bba_cmd_t             cmd,
  output bba_stat_t                 st,
  output out_item_t                 out_data,
  output logic                      ram_we,
  output logic      [AW-1:0]        ram_waddr,
  output logic      [WORD_BITS-1:0] ram_wdata,
  output logic                      ram_re,
  output logic      [AW-1:0]        ram_raddr,
  input  wire logic [WORD_BITS-1:0] ram_rdata
);

  // Configuration and allocator state
  logic [REG_W-1:0] cylinders;
  logic [REG_W-1:0] sectors;
  logic             inodes_enabled;
  logic [CNT_W-1:0] total_blocks;
  logic [CNT_W-1:0] free_blocks;
  logic [CNT_W-1:0] data_base;
  logic [AW:0]      wcnt;
  logic             rd_vld;

  // Item and result payload
  logic [1:0]       op_q;
  logic [BLK_W-1:0] bno_q;
  logic [AW-1:0]    rd_idx;
  logic [BLK_W-1:0] res_blk;
  logic [1:0]       res_status;
  out_item_t        out_q;

  logic [2*REG_W-1:0]   prod;
  logic [CNT_W-1:0]     total_n;
  logic [CNT_W-1:0]     ds_n;
  logic [CNT_W-1:0]     free_n;
  logic [CNT_W-1:0]     wc_base;
  logic [CNT_W-1:0]     fmt_fill;
  logic [WORD_BITS-1:0] fmt_word;
  logic                 can_issue;
  logic [CNT_W-1:0]     rd_lim;
  logic [WORD_BITS-1:0] eff_word;
  logic                 hit;
  logic [BW-1:0]        pos;
  logic [AW-1:0]        bno_word;
  logic [BW-1:0]        bno_bit;

  // Bits below a limit, counted from bit zero of a word
  function automatic logic [WORD_BITS-1:0] below_mask(input logic [CNT_W-1:0] lim);
    logic [WORD_BITS-1:0] m;
    for (int b = 0; b < WORD_BITS; b++) begin
      m[b] = CNT_W'(b) < lim;
    end
    return m;
  endfunction

  // Format geometry: total, first data block, free count
  always_comb begin
    prod    = (2*REG_W)'(cylinders) * (2*REG_W)'(sectors);
    total_n = (prod > (2*REG_W)'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(prod);
    ds_n    = CNT_W'(total_n / BITS_PER_MAP_BLOCK) + CNT_W'(1)
            + (inodes_enabled ? CNT_W'(2 + INODE_BLOCKS) : CNT_W'(1));
    free_n  = (ds_n <= total_n) ? total_n - ds_n : '0;
  end

  // Format word: reserved bits set, the rest clear
  assign wc_base  = {wcnt, {BW{1'b0}}};
  assign fmt_fill = (data_base > wc_base) ? data_base - wc_base : '0;
  assign fmt_word = below_mask(fmt_fill);

  // Scan: issue while the word starts below total, pad bits past total as used
  assign can_issue = wc_base < total_blocks;
  assign rd_lim    = total_blocks - {1'b0, rd_idx, {BW{1'b0}}};
  assign eff_word  = ram_rdata | ~below_mask(rd_lim);
  assign hit       = ~&eff_word;

  // Lowest clear bit of the returned word
  always_comb begin
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!eff_word[b]) begin
        pos = BW'(b);
      end
    end
  end

  assign bno_word = AW'(bno_q >> BW);
  assign bno_bit  = bno_q[BW-1:0];

  // Map memory ports
  always_comb begin
    ram_we    = cmd.fmt_write | cmd.alloc_commit | cmd.free_commit;
    ram_waddr = cmd.fmt_write ? wcnt[AW-1:0] : (cmd.alloc_commit ? rd_idx : bno_word);
    if (cmd.fmt_write) begin
      ram_wdata = fmt_word;
    end else if (cmd.alloc_commit) begin
      ram_wdata = ram_rdata | (WORD_BITS'(1) << pos);
    end else begin
      ram_wdata = ram_rdata & ~(WORD_BITS'(1) << bno_bit);
    end
    ram_re    = (cmd.scan && can_issue) || cmd.free_read;
    ram_raddr = cmd.free_read ? bno_word : wcnt[AW-1:0];
  end

  // Status to controller
  always_comb begin
    st.op         = op_q;
    st.count_zero = (free_blocks == '0);
    st.bno_range  = CNT_W'(bno_q) >= total_blocks;
    st.fmt_last   = (wcnt == (AW+1)'(WORDS - 1));
    st.scan_hit   = rd_vld && hit;
    st.scan_done  = !rd_vld && !can_issue;
    st.bit_used   = ram_rdata[bno_bit];
  end

  // Control and allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      cylinders      <= REG_W'(1);
      sectors        <= REG_W'(1);
      inodes_enabled <= 1'b0;
      total_blocks   <= '0;
      free_blocks    <= '0;
      data_base      <= '0;
      wcnt           <= '0;
      rd_vld         <= 1'b0;
      op_q           <= OP_FORMAT;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CYLINDERS: cylinders      <= cfg_data;
          REG_SECTORS:   sectors        <= cfg_data;
          REG_INODES:    inodes_enabled <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        op_q <= in_data.op;
        wcnt <= '0;
      end else if (cmd.fmt_write || (cmd.scan && can_issue)) begin
        wcnt <= wcnt + 1'b1;
      end
      rd_vld <= cmd.scan && can_issue;
      if (cmd.geom) begin
        total_blocks <= total_n;
        data_base    <= ds_n;
        free_blocks  <= free_n;
      end else if (cmd.alloc_commit) begin
        free_blocks <= free_blocks - 1'b1;
      end else if (cmd.free_commit) begin
        free_blocks <= free_blocks + 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx <= wcnt[AW-1:0];
    if (cmd.start) begin
      bno_q      <= in_data.block_number;
      res_blk    <= '0;
      res_status <= ST_OK;
    end else begin
      if (cmd.alloc_commit) begin
        res_blk <= BLK_W'({rd_idx, pos});
      end
      if (cmd.status_we) begin
        res_status <= cmd.status_val;
      end
    end
    if (cmd.finish) begin
      out_q.allocated_block <= res_blk;
      out_q.status          <= res_status;
      out_q.free_count      <= free_blocks;
    end
  end

  assign out_data = out_q;

endmodule

`default_nettype wire

// File: rtl/bba_checker.sv
// Port-level checker for the bitmap block allocator and its bind statement.
`default_nettype none
`include "bitmap_block_allocator_macros.svh"

module bba_checker import bba_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire out_item_t         out_data
);

  // A granted block only comes with an ok status
  `BBA_ASSERT_SAME(a_grant_ok, clk, rst, out_valid && out_data.allocated_block != '0, out_data.status == ST_OK, "block granted with error status")

  // Free count never exceeds the disk size
  `BBA_ASSERT_SAME(a_count_max, clk, rst, out_valid, out_data.free_count <= CNT_W'(MAX_BLOCKS), "free count above disk size")

  // One item at a time: ready drops after an accept
  `BBA_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready, "item accepted while busy")

  // A stalled result holds
  `BBA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind bitmap_block_allocator bba_checker u_chk (.*);

`default_nettype wire
